FILE: hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by the register file top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/usbnic_pkg.sv
// types, constants and tables of the usb nic register window
package usbnic_pkg;

   localparam int WINDOW_BYTES_DEF = 48;
   localparam logic [15:0] WINDOW_BASE = 16'd288;
   localparam int MAX_ACCESS_BYTES = 8;
   localparam int MAC_BITS = 48;

   localparam int OFS_CR = 'h0e;
   localparam int OFS_MSR = 'h17;
   localparam int OFS_PHYDAT = 'h19;
   localparam int OFS_PHYCNT = 'h1b;
   localparam int OFS_BMCR_HI = 'h21;
   localparam int OFS_BMSR = 'h22;
   localparam int OFS_CSCR = 'h2c;

   localparam logic [7:0] SOFT_RESET_BIT = 8'h10;
   localparam logic [7:0] MII_GO = 8'h40;
   localparam logic [7:0] MII_WRITE = 8'h20;
   localparam logic [7:0] MII_REG_MASK = 8'h1f;
   localparam logic [7:0] MEDIA_ON = 8'h1c;
   localparam logic [7:0] CSCR_LINK = 8'h08;
   localparam logic [7:0] BMSR_RESET = 8'h2d;
   localparam logic [7:0] BMCR_HI_RESET = 8'h30;

   typedef enum logic [1:0] {
      CMD_READ       = 2'd0,
      CMD_WRITE      = 2'd1,
      CMD_INT_STATUS = 2'd2,
      CMD_DEV_RESET  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] address;
      logic [7:0]  length;
      logic [63:0] write_data;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [63:0] read_data;
      logic [3:0]  byte_count;
   } rsp_type;

   // phy register contents returned by an mii read
   function automatic logic [15:0] phy_value(input logic [7:0] reg_num);
      logic [15:0] v;
      case (reg_num)
         8'd0: v = 16'h3100;
         8'd1: v = 16'h782d;
         8'd2: v = 16'h0000;
         8'd3: v = 16'h8201;
         8'd4: v = 16'h01e1;
         8'd5: v = 16'h45e1;
         default: v = 16'h0000;
      endcase
      return v;
   endfunction

   // power-on contents of one register byte
   function automatic logic [7:0] default_byte(input int k, input logic [MAC_BITS-1:0] mac);
      logic [7:0] b;
      b = 8'h00;
      if (k < 6) begin
         b = mac[8*k +: 8];
      end else begin
         case (k)
            OFS_MSR: b = MEDIA_ON;
            OFS_BMSR: b = BMSR_RESET;
            OFS_BMCR_HI: b = BMCR_HI_RESET;
            OFS_CSCR: b = CSCR_LINK;
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

FILE: hw/rtl/usbnic_if.sv
// valid/ready channel interfaces for request and response items
interface nic_req_if;
   import usbnic_pkg::*;
   logic        valid;
   logic        ready;
   cmd_type     cmd;
   logic [15:0] address;
   logic [7:0]  length;
   logic [63:0] write_data;
   modport source(output valid, cmd, address, length, write_data, input ready);
   modport sink(input valid, cmd, address, length, write_data, output ready);
endinterface

interface nic_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [63:0] read_data;
   logic [3:0]  byte_count;
   modport source(output valid, status, read_data, byte_count, input ready);
   modport sink(input valid, status, read_data, byte_count, output ready);
endinterface

FILE: hw/rtl/usbnic_access.sv
// decode of one item: window check, byte-lane read and write, side effects, interrupt status and device reset
module usbnic_access #(
   parameter int WINDOW_BYTES = usbnic_pkg::WINDOW_BYTES_DEF
) (
   input  usbnic_pkg::req_type                    item,
   input  logic [8*WINDOW_BYTES-1:0]              regs,
   input  logic [usbnic_pkg::MAC_BITS-1:0]        mac,
   output logic [8*WINDOW_BYTES-1:0]              regs_next,
   output usbnic_pkg::rsp_type                    rsp
);
   import usbnic_pkg::*;

   localparam int OFS_W = $clog2(WINDOW_BYTES);
   localparam int REG_BITS = 8 * WINDOW_BYTES;
   localparam logic [16:0] WINDOW_END = 17'(int'(WINDOW_BASE) + WINDOW_BYTES);

   logic [16:0]       end_addr;
   logic              stall;
   logic [OFS_W-1:0]  ofs;
   logic [OFS_W:0]    ofs_lo;
   logic [OFS_W:0]    ofs_hi;
   logic [REG_BITS-1:0] shifted;
   logic [OFS_W:0]    lane;
   logic [7:0]        cnt;
   logic [15:0]       phy;

   assign end_addr = {1'b0, item.address} + {9'b0, item.length};
   assign stall = (item.length > 8'(MAX_ACCESS_BYTES)) || (item.address < WINDOW_BASE) ||
                  (end_addr > WINDOW_END);
   assign ofs = OFS_W'(item.address - WINDOW_BASE);
   assign ofs_lo = {1'b0, ofs};
   assign ofs_hi = ofs_lo + (OFS_W+1)'(item.length[3:0]);
   assign shifted = regs >> {ofs, 3'b000};

   always_comb begin
      rsp = '0;
      regs_next = regs;
      lane = '0;
      cnt = '0;
      phy = '0;
      case (item.cmd)
         CMD_INT_STATUS: begin
            rsp.read_data = {40'b0, regs[8*OFS_MSR +: 8], 16'b0};
            rsp.byte_count = 4'(MAX_ACCESS_BYTES);
         end
         CMD_DEV_RESET: begin
            for (int k = 0; k < WINDOW_BYTES; k++) begin
               regs_next[8*k +: 8] = default_byte(k, mac);
            end
         end
         CMD_READ: begin
            if (stall) begin
               rsp.status = 1'b1;
            end else begin
               for (int i = 0; i < MAX_ACCESS_BYTES; i++) begin
                  if (4'(i) < item.length[3:0]) begin
                     rsp.read_data[8*i +: 8] = shifted[8*i +: 8];
                  end
               end
               rsp.byte_count = item.length[3:0];
            end
         end
         CMD_WRITE: begin
            if (stall) begin
               rsp.status = 1'b1;
            end else begin
               for (int k = 0; k < WINDOW_BYTES; k++) begin
                  lane = (OFS_W+1)'(k) - ofs_lo;
                  if ((OFS_W+1)'(k) >= ofs_lo && (OFS_W+1)'(k) < ofs_hi) begin
                     regs_next[8*k +: 8] = item.write_data[{lane[2:0], 3'b000} +: 8];
                  end
               end
               if (ofs_lo <= (OFS_W+1)'(OFS_CR) && ofs_hi > (OFS_W+1)'(OFS_CR)) begin
                  regs_next[8*OFS_CR +: 8] = regs_next[8*OFS_CR +: 8] & ~SOFT_RESET_BIT;
               end
               cnt = regs_next[8*OFS_PHYCNT +: 8];
               phy = phy_value(cnt & MII_REG_MASK);
               if (ofs_lo <= (OFS_W+1)'(OFS_PHYCNT) && ofs_hi > (OFS_W+1)'(OFS_PHYCNT) &&
                   (cnt & MII_GO) != 8'h00) begin
                  if ((cnt & MII_WRITE) == 8'h00) begin
                     regs_next[8*OFS_PHYDAT +: 16] = phy;
                  end
                  regs_next[8*OFS_PHYCNT +: 8] = cnt & ~MII_GO;
               end
               regs_next[8*OFS_MSR +: 8] = MEDIA_ON;
               regs_next[8*OFS_CSCR +: 8] = regs_next[8*OFS_CSCR +: 8] | CSCR_LINK;
            end
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/usb_nic_register_file.sv
// top level of the usb nic register window
//
//   channel   direction  payload
//   req_ch    in         cmd, address, length, write_data
//   rsp_ch    out        status, read_data, byte_count
//   csr_*     in         station_address (write only)
//
// one item per cycle sustained while the receiver keeps rsp_ch.ready high; an item passes
// through the input register, then the byte-lane update into the result register
// the register file is a flop vector read and written in the same cycle
// reset is synchronous and reloads the defaults with an all-zero mac
// a stalled result holds the result register; the input register fills
// behind it and req_ch.ready drops only when both are occupied
module usb_nic_register_file #(
   parameter int WINDOW_BYTES = usbnic_pkg::WINDOW_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   nic_req_if.sink                         req_ch,
   nic_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [usbnic_pkg::MAC_BITS-1:0] csr_write_data
);
   import usbnic_pkg::*;

   localparam int REG_BITS = 8 * WINDOW_BYTES;

   logic [MAC_BITS-1:0] station_ff, station_in;
   logic                req_valid_ff, req_valid_in;
   req_type             req_item_ff, req_item_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_item_ff, rsp_item_in;
   logic [REG_BITS-1:0] regs_ff, regs_in;

   logic [REG_BITS-1:0] regs_next;
   logic [REG_BITS-1:0] reset_image;
   rsp_type             rsp_calc;
   logic                rsp_free;
   logic                advance;
   logic                req_take;

   logic [7:0]          msr_byte;
   logic [7:0]          cscr_byte;
   logic                rsp_stalled;
   logic                rsp_blank;
   logic                req_waiting;

   usbnic_access #(
      .WINDOW_BYTES(WINDOW_BYTES)
   ) u_access (
      .item      (req_item_ff),
      .regs      (regs_ff),
      .mac       (station_ff),
      .regs_next (regs_next),
      .rsp       (rsp_calc)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign advance = req_valid_ff && rsp_free;
   assign req_ch.ready = !req_valid_ff || advance;
   assign req_take = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_item_ff.status;
   assign rsp_ch.read_data = rsp_item_ff.read_data;
   assign rsp_ch.byte_count = rsp_item_ff.byte_count;

   always_comb begin
      for (int k = 0; k < WINDOW_BYTES; k++) begin
         reset_image[8*k +: 8] = default_byte(k, '0);
      end
   end

   always_comb begin
      station_in = csr_write_enable ? csr_write_data : station_ff;
      req_valid_in = req_take || (req_valid_ff && !advance);
      req_item_in = req_item_ff;
      if (req_take) begin
         req_item_in.cmd = req_ch.cmd;
         req_item_in.address = req_ch.address;
         req_item_in.length = req_ch.length;
         req_item_in.write_data = req_ch.write_data;
      end
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);
      rsp_item_in = advance ? rsp_calc : rsp_item_ff;
      regs_in = advance ? regs_next : regs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= '0;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         regs_ff <= reset_image;
      end else begin
         station_ff <= station_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         regs_ff <= regs_in;
      end
      req_item_ff <= req_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign msr_byte = regs_ff[8*OFS_MSR +: 8];
   assign cscr_byte = regs_ff[8*OFS_CSCR +: 8];
   assign rsp_stalled = rsp_valid_ff && rsp_item_ff.status;
   assign rsp_blank = (rsp_item_ff.read_data == '0) && (rsp_item_ff.byte_count == '0);
   assign req_waiting = req_valid_ff && !advance;

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_media_on, clock, reset, msr_byte == MEDIA_ON, "media status lost")
   `ASSERT_ALWAYS(a_link_on, clock, reset, (cscr_byte & CSCR_LINK) == CSCR_LINK, "link bit lost")
   `ASSERT_IMPL(a_stall_empty, clock, reset, rsp_stalled, rsp_blank, "stalled item carries data")
   `ASSERT_NEXT(a_input_hold, clock, reset, req_waiting, req_valid_ff && $stable(req_item_ff), "item lost")

endmodule

FILE: tb/sv/usb_nic_register_file_checker.sv
// checker for the usb nic register window: predicts every response and compares it
`timescale 1ns / 1ps

module usb_nic_register_file_checker (
   input  logic                            clock,
   input  logic                            reset,
   nic_req_if                              req_ch,
   nic_rsp_if                              rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [usbnic_pkg::MAC_BITS-1:0] csr_write_data,
   output int                              pending,
   output int                              failures
);
   import usbnic_pkg::*;

   localparam int WIN_BYTES = WINDOW_BYTES_DEF;
   localparam logic [15:0] PHY_ROM [0:5] = '{
      16'h3100, 16'h782d, 16'h0000, 16'h8201, 16'h01e1, 16'h45e1
   };

   logic [7:0]          regs [0:WIN_BYTES-1];
   logic [MAC_BITS-1:0] mac;
   rsp_type             owed_rsp [$];

   function automatic void reload_regs();
      for (int k = 0; k < WIN_BYTES; k++) begin
         regs[k] = 8'h00;
      end
      for (int k = 0; k < 6; k++) begin
         regs[k] = mac[8*k +: 8];
      end
      regs[OFS_MSR] = MEDIA_ON;
      regs[OFS_BMSR] = BMSR_RESET;
      regs[OFS_BMCR_HI] = BMCR_HI_RESET;
      regs[OFS_CSCR] = CSCR_LINK;
   endfunction

   function automatic rsp_type apply_access(input cmd_type cmd, input logic [15:0] addr,
                                            input logic [7:0] len, input logic [63:0] wdata);
      rsp_type     r;
      int          ofs;
      int          reg_num;
      logic [7:0]  cnt;
      logic [15:0] pv;
      r = '0;
      case (cmd)
         CMD_INT_STATUS: begin
            r.read_data = {40'd0, regs[OFS_MSR], 16'd0};
            r.byte_count = 4'd8;
         end
         CMD_DEV_RESET: begin
            reload_regs();
         end
         default: begin
            if (int'(len) > MAX_ACCESS_BYTES || addr < WINDOW_BASE ||
                int'(addr) + int'(len) > int'(WINDOW_BASE) + WIN_BYTES) begin
               r.status = 1'b1;
            end else begin
               ofs = int'(addr) - int'(WINDOW_BASE);
               if (cmd == CMD_READ) begin
                  for (int i = 0; i < int'(len); i++) begin
                     r.read_data[8*i +: 8] = regs[ofs+i];
                  end
                  r.byte_count = len[3:0];
               end else begin
                  for (int i = 0; i < int'(len); i++) begin
                     regs[ofs+i] = wdata[8*i +: 8];
                  end
                  if (OFS_CR >= ofs && OFS_CR < ofs + int'(len)) begin
                     regs[OFS_CR] = regs[OFS_CR] & ~SOFT_RESET_BIT;
                  end
                  if (OFS_PHYCNT >= ofs && OFS_PHYCNT < ofs + int'(len)) begin
                     cnt = regs[OFS_PHYCNT];
                     if ((cnt & MII_GO) != 8'h00) begin
                        if ((cnt & MII_WRITE) == 8'h00) begin
                           reg_num = int'(cnt & MII_REG_MASK);
                           pv = (reg_num < 6) ? PHY_ROM[reg_num] : 16'h0000;
                           regs[OFS_PHYDAT] = pv[7:0];
                           regs[OFS_PHYDAT+1] = pv[15:8];
                        end
                        regs[OFS_PHYCNT] = cnt & ~MII_GO;
                     end
                  end
                  regs[OFS_MSR] = MEDIA_ON;
                  regs[OFS_CSCR] = regs[OFS_CSCR] | CSCR_LINK;
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         mac = '0;
         reload_regs();
         owed_rsp.delete();
         failures = 0;
      end else begin
         if (csr_write_enable) begin
            mac = csr_write_data;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_rsp.size() == 0) begin
               $display("%0t: unexpected item status %0b read_data %h byte_count %0d",
                        $time, rsp_ch.status, rsp_ch.read_data, rsp_ch.byte_count);
               failures++;
            end else begin
               want = owed_rsp.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: status expected %0b actual %0b",
                           $time, want.status, rsp_ch.status);
                  failures++;
               end
               if (rsp_ch.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.read_data, rsp_ch.read_data);
                  failures++;
               end
               if (rsp_ch.byte_count !== want.byte_count) begin
                  $display("%0t: byte_count expected %0d actual %0d",
                           $time, want.byte_count, rsp_ch.byte_count);
                  failures++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            owed_rsp.push_back(apply_access(req_ch.cmd, req_ch.address, req_ch.length,
                                            req_ch.write_data));
         end
      end
      pending = owed_rsp.size();
   end

endmodule

FILE: tb/sv/usb_nic_register_file_tb.sv
// top of the usb nic register window testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module usb_nic_register_file_tb;
   import usbnic_pkg::*;

   localparam int WIN_BYTES = WINDOW_BYTES_DEF;
   localparam int PHASE_ITEMS = 500;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [MAC_BITS-1:0] csr_write_data = '0;
   int                  pending;
   int                  failures;
   int                  idle_mode = 0;
   bit                  hold_request = 1'b0;
   int                  timer_cycles = 0;

   nic_req_if req_ch ();
   nic_rsp_if rsp_ch ();

   usb_nic_register_file u_top (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   usb_nic_register_file_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pending          (pending),
      .failures         (failures)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      timer_cycles <= timer_cycles + 1;
      if (timer_cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int sender_idle_pct();
      return (idle_mode == 1) ? 54 : (idle_mode == 3) ? 35 : 0;
   endfunction

   function automatic int receiver_stall_pct();
      return (idle_mode == 2) ? 54 : (idle_mode == 3) ? 35 : 0;
   endfunction

   // receiver side, with one long hold-off on request
   initial begin : receiver
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= receiver_stall_pct());
         end
      end
   end

   task automatic send_access(input cmd_type cmd, input logic [15:0] addr,
                              input logic [7:0] len, input logic [63:0] wdata);
      while ($urandom_range(99) < sender_idle_pct()) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.cmd = cmd;
      req_ch.address = addr;
      req_ch.length = len;
      req_ch.write_data = wdata;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic set_station(input logic [MAC_BITS-1:0] value);
      wait_drained();
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic random_access();
      int          sel;
      int          ofs;
      int          max_len;
      cmd_type     cmd;
      logic [15:0] addr;
      logic [7:0]  len;
      logic [63:0] wdata;
      sel = $urandom_range(99);
      if (sel < 38) begin
         cmd = CMD_READ;
      end else if (sel < 83) begin
         cmd = CMD_WRITE;
      end else if (sel < 95) begin
         cmd = CMD_INT_STATUS;
      end else begin
         cmd = CMD_DEV_RESET;
      end
      wdata = {$urandom, $urandom};
      sel = $urandom_range(99);
      if (sel < 80) begin
         ofs = $urandom_range(WIN_BYTES - 1);
         max_len = (WIN_BYTES - ofs < MAX_ACCESS_BYTES) ? WIN_BYTES - ofs : MAX_ACCESS_BYTES;
         len = 8'($urandom_range(max_len));
         addr = 16'(int'(WINDOW_BASE) + ofs);
      end else if (sel < 88) begin
         len = 8'($urandom_range(MAX_ACCESS_BYTES, 1));
         if ($urandom_range(1) == 1) begin
            addr = 16'(int'(WINDOW_BASE) + WIN_BYTES - int'(len) + 1);
         end else begin
            addr = WINDOW_BASE - 16'd1;
         end
      end else begin
         addr = 16'($urandom);
         len = 8'($urandom);
      end
      // mii command byte on its own, mostly with go set
      if (cmd == CMD_WRITE && $urandom_range(99) < 20) begin
         addr = 16'(int'(WINDOW_BASE) + OFS_PHYCNT);
         len = 8'd1;
         wdata[4:0] = 5'($urandom_range(7));
         wdata[5] = ($urandom_range(99) < 30);
         wdata[6] = ($urandom_range(99) < 75);
      end
      send_access(cmd, addr, len, wdata);
   endtask

   initial begin : stimulus
      logic [MAC_BITS-1:0] macs [0:3];
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_READ;
      req_ch.address = '0;
      req_ch.length = '0;
      req_ch.write_data = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      set_station('1);
      send_access(CMD_DEV_RESET, 16'h0000, 8'd0, 64'd0);
      send_access(CMD_READ, WINDOW_BASE, 8'd8, 64'd0);
      send_access(CMD_READ, WINDOW_BASE + 16'h10, 8'd8, 64'd0);
      send_access(CMD_READ, WINDOW_BASE + 16'h20, 8'd8, 64'd0);
      send_access(CMD_READ, WINDOW_BASE + 16'h28, 8'd8, 64'd0);
      send_access(CMD_READ, WINDOW_BASE + 16'h29, 8'd8, 64'd0);
      send_access(CMD_WRITE, WINDOW_BASE - 16'd1, 8'd1, '1);
      send_access(CMD_READ, WINDOW_BASE, 8'd9, 64'd0);
      send_access(CMD_WRITE, 16'hffff, 8'hff, '1);
      send_access(CMD_READ, 16'h0000, 8'd0, 64'd0);
      send_access(CMD_READ, WINDOW_BASE + 16'd47, 8'd0, 64'd0);
      send_access(CMD_WRITE, WINDOW_BASE + 16'h2c, 8'd1, 64'd0);
      send_access(CMD_WRITE, WINDOW_BASE + 16'h10, 8'd8, 64'd0);
      send_access(CMD_WRITE, WINDOW_BASE + 16'd48, 8'd0, '1);
      send_access(CMD_INT_STATUS, 16'hffff, 8'hff, '1);
      send_access(CMD_WRITE, WINDOW_BASE + 16'h08, 8'd8, '1);
      send_access(CMD_WRITE, WINDOW_BASE + 16'h1b, 8'd1, 64'h41);
      send_access(CMD_READ, WINDOW_BASE + 16'h18, 8'd4, 64'd0);
      send_access(CMD_WRITE, WINDOW_BASE + 16'h1b, 8'd1, 64'h47);
      send_access(CMD_WRITE, WINDOW_BASE + 16'h19, 8'd3, 64'h7fbeef);
      send_access(CMD_READ, WINDOW_BASE + 16'h18, 8'd8, 64'd0);
      send_access(CMD_READ, WINDOW_BASE + 16'h08, 8'd8, 64'd0);
      send_access(CMD_DEV_RESET, 16'hffff, 8'hff, '1);
      send_access(CMD_READ, WINDOW_BASE + 16'h28, 8'd8, 64'd0);

      macs[0] = '0;
      macs[1] = 48'({$urandom, $urandom});
      macs[2] = 48'h0123_4567_89ab;
      macs[3] = 48'({$urandom, $urandom});
      for (int p = 0; p < 4; p++) begin
         set_station(macs[p]);
         idle_mode = p;
         send_access(CMD_DEV_RESET, 16'h0000, 8'd0, 64'd0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 0 && i == 100) begin
               hold_request = 1'b1;
            end
            random_access();
         end
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/usbnic_pkg.sv
hw/rtl/usbnic_if.sv
hw/rtl/usbnic_access.sv
hw/rtl/usb_nic_register_file.sv
tb/sv/usb_nic_register_file_checker.sv
tb/sv/usb_nic_register_file_tb.sv
